[rtl/qvr_pkg.sv]
// Shared types and widths for the quaternion vector rotation pipeline.
// Depends on nothing; every other rtl file imports it.
`default_nettype none

package qvr_pkg;

    localparam int DATA_W  = 16;                // quaternion and vector components
    localparam int PROD1_W = 2 * DATA_W;        // component times component
    localparam int T_W     = PROD1_W + 1;       // sum of three first products
    localparam int PROD2_W = DATA_W + T_W;      // component times t term
    localparam int R_W     = PROD2_W + 3;       // sum of four second products
    localparam int FRAC_BITS = 28;              // fraction bits of the result
    localparam int RND_W   = R_W + 1 - FRAC_BITS;

    typedef struct packed {
        logic signed [DATA_W-1:0] w;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
    } qvr_quat_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
    } qvr_vec_t;

    // t = p * conj(q), all four parts
    typedef struct packed {
        logic signed [T_W-1:0] t0;
        logic signed [T_W-1:0] t1;
        logic signed [T_W-1:0] t2;
        logic signed [T_W-1:0] t3;
    } qvr_tquat_t;

    // vector part of q * t, 28 fraction bits
    typedef struct packed {
        logic signed [R_W-1:0] r1;
        logic signed [R_W-1:0] r2;
        logic signed [R_W-1:0] r3;
    } qvr_rvec_t;

endpackage

`default_nettype wire

[rtl/qvr_ham1.sv]
// First Hamilton product t = (0, v) * conj(q): product stage, then sum stage.
// Depends on qvr_pkg.
`default_nettype none

module qvr_ham1
    import qvr_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire qvr_quat_t  in_quat,
    input  wire qvr_vec_t   in_vec,
    output logic            out_valid,
    input  wire logic       out_ready,
    output qvr_quat_t       out_quat,
    output qvr_tquat_t      out_t
);

    localparam int NPROD = 12;

    logic                       valid_a_reg, valid_b_reg;
    logic                       en_a, en_b;
    logic signed [PROD1_W-1:0]  prod_reg  [NPROD];
    logic signed [PROD1_W-1:0]  prod_next [NPROD];
    qvr_quat_t                  quat_a_reg, quat_b_reg;
    qvr_tquat_t                 t_reg, t_next;

    // a stage moves when it is empty or the next one moves
    assign en_b     = !valid_b_reg || out_ready;
    assign en_a     = !valid_a_reg || en_b;
    assign in_ready = en_a;

    // form the twelve component products
    always_comb begin
        prod_next[0]  = in_vec.x * in_quat.x;
        prod_next[1]  = in_vec.y * in_quat.y;
        prod_next[2]  = in_vec.z * in_quat.z;
        prod_next[3]  = in_vec.x * in_quat.w;
        prod_next[4]  = in_vec.y * in_quat.z;
        prod_next[5]  = in_vec.z * in_quat.y;
        prod_next[6]  = in_vec.x * in_quat.z;
        prod_next[7]  = in_vec.y * in_quat.w;
        prod_next[8]  = in_vec.z * in_quat.x;
        prod_next[9]  = in_vec.x * in_quat.y;
        prod_next[10] = in_vec.y * in_quat.x;
        prod_next[11] = in_vec.z * in_quat.w;
    end

    // add the products into the four parts of t
    always_comb begin
        t_next.t0 = T_W'(prod_reg[0]) + T_W'(prod_reg[1]) + T_W'(prod_reg[2]);
        t_next.t1 = T_W'(prod_reg[3]) - T_W'(prod_reg[4]) + T_W'(prod_reg[5]);
        t_next.t2 = T_W'(prod_reg[6]) + T_W'(prod_reg[7]) - T_W'(prod_reg[8]);
        t_next.t3 = T_W'(prod_reg[10]) - T_W'(prod_reg[9]) + T_W'(prod_reg[11]);
    end

    // hold valid bits under stall
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end else begin
            if (en_a) valid_a_reg <= in_valid;
            if (en_b) valid_b_reg <= valid_a_reg;
        end
    end

    // advance payload
    always_ff @(posedge aclk) begin
        if (en_a) begin
            prod_reg   <= prod_next;
            quat_a_reg <= in_quat;
        end
        if (en_b) begin
            t_reg      <= t_next;
            quat_b_reg <= quat_a_reg;
        end
    end

    assign out_valid = valid_b_reg;
    assign out_quat  = quat_b_reg;
    assign out_t     = t_reg;

endmodule

`default_nettype wire

[rtl/qvr_ham2.sv]
// Second Hamilton product r = q * t, vector part only: product and sum stages.
// Depends on qvr_pkg.
`default_nettype none

module qvr_ham2
    import qvr_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire qvr_quat_t  in_quat,
    input  wire qvr_tquat_t in_t,
    output logic            out_valid,
    input  wire logic       out_ready,
    output qvr_rvec_t       out_r
);

    localparam int NPROD = 12;

    logic                       valid_a_reg, valid_b_reg;
    logic                       en_a, en_b;
    logic signed [PROD2_W-1:0]  prod_reg  [NPROD];
    logic signed [PROD2_W-1:0]  prod_next [NPROD];
    qvr_rvec_t                  r_reg, r_next;

    assign en_b     = !valid_b_reg || out_ready;
    assign en_a     = !valid_a_reg || en_b;
    assign in_ready = en_a;

    // form the products that feed the vector part
    always_comb begin
        prod_next[0]  = in_quat.w * in_t.t1;
        prod_next[1]  = in_quat.x * in_t.t0;
        prod_next[2]  = in_quat.y * in_t.t3;
        prod_next[3]  = in_quat.z * in_t.t2;
        prod_next[4]  = in_quat.w * in_t.t2;
        prod_next[5]  = in_quat.x * in_t.t3;
        prod_next[6]  = in_quat.y * in_t.t0;
        prod_next[7]  = in_quat.z * in_t.t1;
        prod_next[8]  = in_quat.w * in_t.t3;
        prod_next[9]  = in_quat.x * in_t.t2;
        prod_next[10] = in_quat.y * in_t.t1;
        prod_next[11] = in_quat.z * in_t.t0;
    end

    // sum with Hamilton signs at full width
    always_comb begin
        r_next.r1 = R_W'(prod_reg[0]) + R_W'(prod_reg[1])
                  + R_W'(prod_reg[2]) - R_W'(prod_reg[3]);
        r_next.r2 = R_W'(prod_reg[4]) - R_W'(prod_reg[5])
                  + R_W'(prod_reg[6]) + R_W'(prod_reg[7]);
        r_next.r3 = R_W'(prod_reg[8]) + R_W'(prod_reg[9])
                  - R_W'(prod_reg[10]) + R_W'(prod_reg[11]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end else begin
            if (en_a) valid_a_reg <= in_valid;
            if (en_b) valid_b_reg <= valid_a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_a) prod_reg <= prod_next;
        if (en_b) r_reg    <= r_next;
    end

    assign out_valid = valid_b_reg;
    assign out_r     = r_reg;

endmodule

`default_nettype wire

[rtl/qvr_round.sv]
// Round-half-up and 16-bit saturation of the rotated vector; output register.
// Depends on qvr_pkg.
`default_nettype none

module qvr_round
    import qvr_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire qvr_rvec_t  in_r,
    output logic            out_valid,
    input  wire logic       out_ready,
    output qvr_vec_t        out_vec,
    output logic            out_ovf
);

    localparam logic signed [R_W:0] HALF_LSB = (R_W+1)'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    logic       valid_reg, en;
    qvr_vec_t   vec_reg, vec_next;
    logic       ovf_reg, ovf_next;
    logic [2:0] sat;
    logic signed [DATA_W-1:0] comp [3];

    // round one component and clip it to 16 bits
    function automatic logic [DATA_W:0] round_sat(input logic signed [R_W-1:0] s);
        logic signed [R_W:0]   biased;
        logic [RND_W-1:0]      rnd;
        logic                  hi, lo;
        biased = (R_W+1)'(s) + HALF_LSB;
        rnd    = biased[R_W:FRAC_BITS];
        hi     = !rnd[RND_W-1] && (|rnd[RND_W-2:DATA_W-1]);
        lo     = rnd[RND_W-1] && !(&rnd[RND_W-2:DATA_W-1]);
        if (hi) begin
            return {1'b1, SAT_MAX};
        end else if (lo) begin
            return {1'b1, SAT_MIN};
        end else begin
            return {1'b0, rnd[DATA_W-1:0]};
        end
    endfunction

    always_comb begin
        {sat[0], comp[0]} = round_sat(in_r.r1);
        {sat[1], comp[1]} = round_sat(in_r.r2);
        {sat[2], comp[2]} = round_sat(in_r.r3);
        vec_next.x = comp[0];
        vec_next.y = comp[1];
        vec_next.z = comp[2];
        ovf_next   = |sat;
    end

    assign en       = !valid_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vec_reg <= vec_next;
            ovf_reg <= ovf_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;
    assign out_ovf   = ovf_reg;

endmodule

`default_nettype wire

[rtl/quaternion_vector_rotate.sv]
// Top level of the quaternion vector rotation pipeline, v' = q * (0,v) * conj(q).
// Depends on qvr_pkg, qvr_ham1, qvr_ham2 and qvr_round.
//
//   channel | direction | ports                              | handshake
//   --------+-----------+------------------------------------+----------------
//   s_      | in        | quat_w/x/y/z (Q1.14), vec_x/y/z    | s_valid/s_ready
//   m_      | out       | out_x/y/z, overflow                | m_valid/m_ready
//
// One request per clock while m_ready is held high; five register stages:
// two stages per Hamilton product (multiply, then add) and one round/saturate stage.
// Each stage has its own valid bit and moves when empty or when its successor moves,
// so bubbles collapse and a stalled m_ready backs up without loss or repeat.
// Reset (aresetn low, synchronous) clears all valid bits; data registers are not reset.
`default_nettype none

module quaternion_vector_rotate
    import qvr_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [15:0] s_quat_w,
    input  wire logic signed [15:0] s_quat_x,
    input  wire logic signed [15:0] s_quat_y,
    input  wire logic signed [15:0] s_quat_z,
    input  wire logic signed [15:0] s_vec_x,
    input  wire logic signed [15:0] s_vec_y,
    input  wire logic signed [15:0] s_vec_z,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_out_x,
    output logic signed [15:0]      m_out_y,
    output logic signed [15:0]      m_out_z,
    output logic                    m_overflow
);

    localparam int DEPTH = 5;
    localparam int CNT_W = $clog2(DEPTH + 1);

    qvr_quat_t  in_quat, h1_quat;
    qvr_vec_t   in_vec, rnd_vec;
    qvr_tquat_t h1_t;
    qvr_rvec_t  h2_r;
    logic       h1_valid, h1_ready, h2_valid, h2_ready;
    logic       s_fire, m_fire;
    logic [CNT_W-1:0] inflight_reg, inflight_next;

    assign in_quat = '{w: s_quat_w, x: s_quat_x, y: s_quat_y, z: s_quat_z};
    assign in_vec  = '{x: s_vec_x, y: s_vec_y, z: s_vec_z};

    qvr_ham1 u_ham1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_quat   (in_quat),
        .in_vec    (in_vec),
        .out_valid (h1_valid),
        .out_ready (h1_ready),
        .out_quat  (h1_quat),
        .out_t     (h1_t)
    );

    qvr_ham2 u_ham2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (h1_valid),
        .in_ready  (h1_ready),
        .in_quat   (h1_quat),
        .in_t      (h1_t),
        .out_valid (h2_valid),
        .out_ready (h2_ready),
        .out_r     (h2_r)
    );

    qvr_round u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (h2_valid),
        .in_ready  (h2_ready),
        .in_r      (h2_r),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_vec   (rnd_vec),
        .out_ovf   (m_overflow)
    );

    assign m_out_x = rnd_vec.x;
    assign m_out_y = rnd_vec.y;
    assign m_out_z = rnd_vec.z;

    // track requests inside the pipeline
    assign s_fire = s_valid && s_ready;
    assign m_fire = m_valid && m_ready;

    always_comb begin
        inflight_next = inflight_reg;
        if (s_fire && !m_fire) begin
            inflight_next = inflight_reg + CNT_W'(1);
        end else if (m_fire && !s_fire) begin
            inflight_next = inflight_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    // never more requests inside than stages
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= CNT_W'(DEPTH))
        else $error("pipeline holds more requests than stages");

    // an empty pipeline always takes a request
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg == '0 |-> s_ready)
        else $error("empty pipeline refuses a request");

    // no result without a request inside
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> inflight_reg != '0)
        else $error("result presented with nothing in flight");

    // overflow only with a clipped component
    a_ovf_clip: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_overflow) |->
            (m_out_x == 16'sh7fff || m_out_x == -16'sh8000 ||
             m_out_y == 16'sh7fff || m_out_y == -16'sh8000 ||
             m_out_z == 16'sh7fff || m_out_z == -16'sh8000))
        else $error("overflow set but no component at a limit");

    // reset empties the output
    a_reset_clear: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

`default_nettype wire
